>>> src/lpt_pkg.sv
// Shared constants, types and codes for the linear-probe table block.
// Used by every module of the block but lpt_ram, and by its checker; depends on nothing.
package lpt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int DENSE_SLOTS   = 4096;
  localparam int KEY_BITS      = 16;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);

  // Fixed field widths
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;
  localparam int SLOT_BITS   = 12;
  localparam int USED_BITS   = 13;
  localparam int LIMIT_BITS  = 13;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [0:0] REG_SLOT_LIMIT = 1'b0;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 13'd4096;

  // Commands
  localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_ABSENT   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_LIMIT    = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_BADKEY   = 3'd6;

  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [USED_BITS-1:0] used_t;

endpackage

>>> src/lpt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered (read-old on collision); no dependencies.
module lpt_ram #(
  parameter int WIDTH     = 16,
  parameter int DEPTH     = 4096,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/lpt_regs.sv
// APB-style configuration register file holding the slot limit.
// Depends on lpt_pkg for widths, register index and reset value.
module lpt_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpt_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [lpt_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [lpt_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output logic [lpt_pkg::LIMIT_BITS-1:0]      slot_limit
);

  logic       wr_en;
  logic [0:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the limit register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= lpt_pkg::LIMIT_RESET;
    end else if (wr_en && reg_idx == lpt_pkg::REG_SLOT_LIMIT) begin
      slot_limit <= pwdata[lpt_pkg::LIMIT_BITS-1:0];
    end
  end

  // Return the register value; unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (reg_idx == lpt_pkg::REG_SLOT_LIMIT) begin
      prdata = lpt_pkg::CFG_DATA_BITS'(slot_limit);
    end
  end

endmodule

>>> src/lpt_core.sv
// Probe sequencer: walks the key memory, binds dense slots, sweeps on clear.
// Depends on lpt_pkg and instantiates two lpt_ram memories (keys and slots).
module lpt_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lpt_pkg::CMD_BITS-1:0]      command,
  input  logic [lpt_pkg::KEY_BITS-1:0]      key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lpt_pkg::STATUS_BITS-1:0]   status,
  output logic [lpt_pkg::SLOT_BITS-1:0]     slot_number,
  output logic [lpt_pkg::USED_BITS-1:0]     slots_used,
  input  logic [lpt_pkg::LIMIT_BITS-1:0]    slot_limit
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_PROBE
  } state_t;

  localparam lpt_pkg::idx_t IDX_LAST = lpt_pkg::IDX_BITS'(lpt_pkg::TABLE_ENTRIES - 1);
  localparam lpt_pkg::key_t HOME_MASK = lpt_pkg::KEY_BITS'(lpt_pkg::TABLE_ENTRIES - 1);
  localparam lpt_pkg::used_t DENSE_MAX = lpt_pkg::USED_BITS'(lpt_pkg::DENSE_SLOTS);

  state_t                            state, state_next;
  lpt_pkg::idx_t                     idx, idx_next;
  lpt_pkg::idx_t                     cnt, cnt_next;
  logic [lpt_pkg::CMD_BITS-1:0]      cmd_q, cmd_q_next;
  lpt_pkg::key_t                     key_q, key_q_next;
  lpt_pkg::used_t                    used_count, used_count_next;
  logic                              out_valid_next;
  logic [lpt_pkg::STATUS_BITS-1:0]   status_next;
  lpt_pkg::slot_t                    slot_number_next;
  lpt_pkg::used_t                    slots_used_next;

  lpt_pkg::key_t  key_rd;
  lpt_pkg::slot_t slot_rd;
  lpt_pkg::key_t  home_wide;
  lpt_pkg::idx_t  home;
  lpt_pkg::idx_t  idx_step;
  logic           accept;
  logic           out_free;
  logic           key_hit;
  logic           key_empty;
  logic           at_limit;
  logic           ins_we;
  logic           key_we;
  lpt_pkg::key_t  key_wdata;

  // Home entry of the incoming key, wrapped into the table
  assign home_wide = key & HOME_MASK;
  assign home      = (32'(home_wide) >= lpt_pkg::TABLE_ENTRIES) ? '0
                                                                : lpt_pkg::IDX_BITS'(home_wide);
  assign idx_step  = (idx == IDX_LAST) ? '0 : idx + 1'b1;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign key_hit   = (key_rd == key_q);
  assign key_empty = (key_rd == '0);
  assign at_limit  = (used_count >= lpt_pkg::USED_BITS'(slot_limit)) ||
                     (used_count >= DENSE_MAX);

  // Next-state and result logic
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    cnt_next         = cnt;
    cmd_q_next       = cmd_q;
    key_q_next       = key_q;
    used_count_next  = used_count;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    slot_number_next = slot_number;
    slots_used_next  = slots_used;
    ins_we           = 1'b0;

    unique case (state)
      S_SWEEP: begin
        if (idx == IDX_LAST) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_q_next = command;
          key_q_next = key;
          idx_next   = home;
          cnt_next   = '0;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        // hold the probe until the result register can take a word
        if (out_free) begin
          priority if (cmd_q == lpt_pkg::CMD_CLEAR) begin
            status_next      = lpt_pkg::ST_FOUND;
            slot_number_next = '0;
            used_count_next  = '0;
            idx_next         = '0;
            out_valid_next   = 1'b1;
            state_next       = S_SWEEP;
          end else if (key_q == '0) begin
            status_next      = lpt_pkg::ST_BADKEY;
            slot_number_next = '0;
            out_valid_next   = 1'b1;
            state_next       = S_IDLE;
          end else if (key_hit || key_empty) begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            priority if (cmd_q == lpt_pkg::CMD_INSERT) begin
              priority if (key_hit) begin
                status_next      = lpt_pkg::ST_PRESENT;
                slot_number_next = slot_rd;
              end else if (at_limit) begin
                status_next      = lpt_pkg::ST_LIMIT;
                slot_number_next = '0;
              end else begin
                status_next      = lpt_pkg::ST_INSERTED;
                slot_number_next = used_count[lpt_pkg::SLOT_BITS-1:0];
                used_count_next  = used_count + 1'b1;
                ins_we           = 1'b1;
              end
            end else begin
              status_next      = key_hit ? lpt_pkg::ST_FOUND : lpt_pkg::ST_ABSENT;
              slot_number_next = key_hit ? slot_rd : '0;
            end
          end else if (cnt == IDX_LAST) begin
            // every entry visited without a match or a hole
            status_next      = (cmd_q == lpt_pkg::CMD_INSERT) ? lpt_pkg::ST_FULL
                                                              : lpt_pkg::ST_ABSENT;
            slot_number_next = '0;
            out_valid_next   = 1'b1;
            state_next       = S_IDLE;
          end else begin
            idx_next = idx_step;
            cnt_next = cnt + 1'b1;
          end
          if (out_valid_next) begin
            slots_used_next = used_count_next;
          end
        end
      end
      default: begin
        state_next = S_SWEEP;
        idx_next   = '0;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      idx        <= '0;
      cnt        <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      cnt        <= cnt_next;
      used_count <= used_count_next;
      out_valid  <= out_valid_next;
    end
    cmd_q       <= cmd_q_next;
    key_q       <= key_q_next;
    status      <= status_next;
    slot_number <= slot_number_next;
    slots_used  <= slots_used_next;
  end

  // Key memory: cleared by the sweep, written on insert
  assign key_we    = (state == S_SWEEP) || ins_we;
  assign key_wdata = (state == S_SWEEP) ? '0 : key_q;

  lpt_ram #(
    .WIDTH (lpt_pkg::KEY_BITS),
    .DEPTH (lpt_pkg::TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (idx),
    .wdata (key_wdata),
    .raddr (idx_next),
    .rdata (key_rd)
  );

  // Slot memory: written only together with a new key
  lpt_ram #(
    .WIDTH (lpt_pkg::SLOT_BITS),
    .DEPTH (lpt_pkg::TABLE_ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (idx),
    .wdata (used_count[lpt_pkg::SLOT_BITS-1:0]),
    .raddr (idx_next),
    .rdata (slot_rd)
  );

endmodule

>>> src/linear_probe_table_insert_lookup.sv
// Linear-probe hash table: maps nonzero keys to dense slot numbers.
// Input channel (in_valid/in_stall) carries a command word: lookup, insert if
// absent, or clear. Output channel (out_valid/out_stall) carries one result word
// per command: status, slot_number and slots_used after the command.
// The APB port writes slot_limit at byte address 0; pready is always high.
// Probing: after a command is accepted the sequencer visits key-memory entries
// from the key's home entry on, one per cycle while the result register is free,
// and registers the result word when the probe ends. A new command is accepted
// only after that result is registered and the sequencer is idle again.
// Clear returns its result and then sweeps the key memory, one entry a cycle,
// with in_stall high. Reset runs the same sweep. While out_stall is high the
// result word holds; a new word may be accepted, and its probe holds at its first
// entry until the result register frees up.
// Configuration writes are accepted at any time.
// Depends on lpt_pkg, lpt_regs, lpt_core and lpt_ram.
module linear_probe_table_insert_lookup (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lpt_pkg::CMD_BITS-1:0]        command,
  input  logic [lpt_pkg::KEY_BITS-1:0]        key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpt_pkg::STATUS_BITS-1:0]     status,
  output logic [lpt_pkg::SLOT_BITS-1:0]       slot_number,
  output logic [lpt_pkg::USED_BITS-1:0]       slots_used,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpt_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [lpt_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [lpt_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready
);

  logic [lpt_pkg::LIMIT_BITS-1:0] slot_limit;

  // Configuration registers
  lpt_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slot_limit (slot_limit)
  );

  // Probe engine and table memories
  lpt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_number (slot_number),
    .slots_used  (slots_used),
    .slot_limit  (slot_limit)
  );

endmodule

>>> src/lpt_checker.sv
// Port-level checker for the linear-probe table, bound to the top level.
// Depends on lpt_pkg for widths and status codes.
module lpt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [lpt_pkg::STATUS_BITS-1:0]     status,
  input logic [lpt_pkg::SLOT_BITS-1:0]       slot_number,
  input logic [lpt_pkg::USED_BITS-1:0]       slots_used
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
                               $stable(slot_number) && $stable(slots_used))
    else $error("result word changed while stalled");

  // Reset empties the output and starts the clearing sweep
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

  // A fresh insert hands out the slot just below the new count
  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == lpt_pkg::ST_INSERTED |->
      slots_used != '0 &&
      slot_number == lpt_pkg::SLOT_BITS'(slots_used - 1'b1))
    else $error("inserted slot does not match count");

  // Failures carry no slot
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == lpt_pkg::ST_ABSENT || status == lpt_pkg::ST_FULL ||
                  status == lpt_pkg::ST_LIMIT || status == lpt_pkg::ST_BADKEY) |->
      slot_number == '0)
    else $error("failed command returned a slot");

  // Status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= lpt_pkg::ST_BADKEY)
    else $error("status code out of range");

endmodule

bind linear_probe_table_insert_lookup lpt_checker u_lpt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .slot_number (slot_number),
  .slots_used  (slots_used)
);
